### rtl/rbsu_pkg.sv
// Shared types and constants for the iRprop- step unit.
// No dependencies; imported by resilient_backprop_step_unit.
package rbsu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int CFG_ADDR_W = 5;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_STEP   = 2'd1,
        OP_SCORE  = 2'd2,
        OP_FINISH = 2'd3
    } opcode_t;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_DELTA_INIT = 3'd0;
    localparam logic [2:0] REG_DELTA_MIN  = 3'd1;
    localparam logic [2:0] REG_DELTA_MAX  = 3'd2;
    localparam logic [2:0] REG_ETA_MINUS  = 3'd3;
    localparam logic [2:0] REG_ETA_PLUS   = 3'd4;
    localparam logic [2:0] REG_EPS_STOP   = 3'd5;
    localparam logic [2:0] REG_MAX_ITER   = 3'd6;

    localparam logic [30:0] RST_DELTA_INIT = 31'd6554;
    localparam logic [30:0] RST_DELTA_MIN  = 31'd1;
    localparam logic [30:0] RST_DELTA_MAX  = 31'd3276800;
    localparam logic [16:0] RST_ETA_MINUS  = 17'd32768;
    localparam logic [30:0] RST_ETA_PLUS   = 31'd78643;
    localparam logic [30:0] RST_EPS_STOP   = 31'd0;
    localparam logic [15:0] RST_MAX_ITER   = 16'd100;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

endpackage

### rtl/resilient_backprop_step_unit.sv
// iRprop- step unit: start, gradient step, score and finish beats.
// An accepted input beat is held in the input register, then lands in the result register.
// Throughput: one beat per cycle while the result is not stalled; the per-lane step multiply,
// parameter update and sum of squares are combinational between the input and result registers.
// Reset: synchronous, active low; clears the valid flags and optimizer state and loads register defaults.
module resilient_backprop_step_unit
    import rbsu_pkg::*;
#(
    parameter int NUM_PARAMS = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // value_0 .. value_N-1 (32b each), score (32b), score_finite (1b), zero pad
    input  logic [((32*NUM_PARAMS+33+7)/8)*8-1:0] s_tdata,
    // opcode (2b)
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // param_0 .. param_N-1 (32b each), stopped (1b), iteration (16b), zero pad
    output logic [((32*NUM_PARAMS+17+7)/8)*8-1:0] m_tdata,
    // result_kind (2b)
    output logic [1:0]            m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int SUM_W = 64 + $clog2(NUM_PARAMS + 1);

    // ---------------- configuration ----------------
    logic [30:0] delta_init_reg, delta_min_reg, delta_max_reg, eta_plus_reg, eps_stop_reg;
    logic [16:0] eta_minus_reg;
    logic [15:0] max_iter_reg;
    logic [61:0] eps_sq_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delta_init_reg <= RST_DELTA_INIT;
            delta_min_reg  <= RST_DELTA_MIN;
            delta_max_reg  <= RST_DELTA_MAX;
            eta_minus_reg  <= RST_ETA_MINUS;
            eta_plus_reg   <= RST_ETA_PLUS;
            eps_stop_reg   <= RST_EPS_STOP;
            max_iter_reg   <= RST_MAX_ITER;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DELTA_INIT: delta_init_reg <= pwdata[30:0];
                REG_DELTA_MIN:  delta_min_reg  <= pwdata[30:0];
                REG_DELTA_MAX:  delta_max_reg  <= pwdata[30:0];
                REG_ETA_MINUS:  eta_minus_reg  <= pwdata[16:0];
                REG_ETA_PLUS:   eta_plus_reg   <= pwdata[30:0];
                REG_EPS_STOP:   eps_stop_reg   <= pwdata[30:0];
                REG_MAX_ITER:   max_iter_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // threshold squared, registered; user writes only while idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        eps_sq_reg <= 62'(eps_stop_reg) * 62'(eps_stop_reg);
    end

    always_comb begin
        case (cfg_idx)
            REG_DELTA_INIT: prdata = {1'b0, delta_init_reg};
            REG_DELTA_MIN:  prdata = {1'b0, delta_min_reg};
            REG_DELTA_MAX:  prdata = {1'b0, delta_max_reg};
            REG_ETA_MINUS:  prdata = {15'b0, eta_minus_reg};
            REG_ETA_PLUS:   prdata = {1'b0, eta_plus_reg};
            REG_EPS_STOP:   prdata = {1'b0, eps_stop_reg};
            REG_MAX_ITER:   prdata = {16'b0, max_iter_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- input register ----------------
    logic                in_vld_reg;
    opcode_t             in_op_reg;
    logic signed [31:0]  in_val_reg [NUM_PARAMS];
    logic signed [31:0]  in_score_reg;
    logic                in_fin_reg;
    logic                out_free, proc, s_fire;
    logic                m_tvalid_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign proc     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg <= opcode_t'(s_tuser);
            for (int i = 0; i < NUM_PARAMS; i++) begin
                in_val_reg[i] <= s_tdata[32*i +: 32];
            end
            in_score_reg <= s_tdata[32*NUM_PARAMS +: 32];
            in_fin_reg   <= s_tdata[32*NUM_PARAMS+32];
        end
    end

    // ---------------- optimizer state ----------------
    logic signed [31:0] cur_reg  [NUM_PARAMS];
    logic signed [31:0] cur_next [NUM_PARAMS];
    logic        [31:0] step_reg  [NUM_PARAMS];
    logic        [31:0] step_next [NUM_PARAMS];
    logic signed [31:0] prev_reg  [NUM_PARAMS];
    logic signed [31:0] prev_next [NUM_PARAMS];
    logic signed [31:0] best_reg  [NUM_PARAMS];
    logic signed [31:0] best_next [NUM_PARAMS];
    logic signed [31:0] best_score_reg, best_score_next;
    logic               any_reg, any_next;
    logic        [15:0] cnt_reg, cnt_next;
    logic               halted_reg, halted_next;

    // per-lane step results
    logic signed [31:0] lane_par  [NUM_PARAMS];
    logic        [31:0] lane_step [NUM_PARAMS];
    logic signed [31:0] lane_grad [NUM_PARAMS];
    logic [SUM_W-1:0]   sumsq;
    logic [15:0]        cnt_inc;
    logic               step_ok;

    always_comb begin
        logic        g_pos, g_neg, p_pos, p_neg, same, flip;
        logic [62:0] grow_prod, grow_sh;
        logic [48:0] shrink_prod, shrink_sh;
        logic [31:0] d, mag;
        logic signed [31:0] g;
        logic signed [33:0] diff;
        sumsq = '0;
        for (int i = 0; i < NUM_PARAMS; i++) begin
            g     = in_val_reg[i];
            g_neg = g[31];
            g_pos = !g[31] && (g != 32'sd0);
            p_neg = prev_reg[i][31];
            p_pos = !prev_reg[i][31] && (prev_reg[i] != 32'sd0);
            same  = (g_pos && p_pos) || (g_neg && p_neg);
            flip  = (g_pos && p_neg) || (g_neg && p_pos);

            grow_prod   = 63'(step_reg[i]) * 63'(eta_plus_reg);
            grow_sh     = grow_prod >> FRAC_BITS;
            shrink_prod = 49'(step_reg[i]) * 49'(eta_minus_reg);
            shrink_sh   = shrink_prod >> FRAC_BITS;

            if (same) begin
                d = (grow_sh > 63'(delta_max_reg)) ? {1'b0, delta_max_reg} : grow_sh[31:0];
            end else if (flip) begin
                d = (shrink_sh < 49'(delta_min_reg)) ? {1'b0, delta_min_reg}
                                                     : shrink_sh[31:0];
                g = 32'sd0;
            end else begin
                d = step_reg[i];
            end

            // move against the sign of the (possibly zeroed) component, saturating
            if (g == 32'sd0) begin
                diff = 34'(cur_reg[i]);
            end else if (g[31]) begin
                diff = 34'(cur_reg[i]) + $signed({2'b00, d});
            end else begin
                diff = 34'(cur_reg[i]) - $signed({2'b00, d});
            end
            if (diff > 34'(S32_MAX)) begin
                lane_par[i] = S32_MAX;
            end else if (diff < 34'(S32_MIN)) begin
                lane_par[i] = S32_MIN;
            end else begin
                lane_par[i] = diff[31:0];
            end

            lane_step[i] = d;
            lane_grad[i] = g;
            mag   = g[31] ? 32'(-g) : 32'(g);
            sumsq = sumsq + SUM_W'(64'(mag) * 64'(mag));
        end
    end

    assign cnt_inc = cnt_reg + 16'd1;
    assign step_ok = !halted_reg && (cnt_reg < max_iter_reg);

    always_comb begin
        cur_next        = cur_reg;
        step_next       = step_reg;
        prev_next       = prev_reg;
        best_next       = best_reg;
        best_score_next = best_score_reg;
        any_next        = any_reg;
        cnt_next        = cnt_reg;
        halted_next     = halted_reg;
        case (in_op_reg)
            OP_START: begin
                for (int i = 0; i < NUM_PARAMS; i++) begin
                    cur_next[i]  = in_val_reg[i];
                    best_next[i] = in_val_reg[i];
                    step_next[i] = {1'b0, delta_init_reg};
                    prev_next[i] = 32'sd0;
                end
                best_score_next = S32_MIN;
                any_next        = 1'b0;
                cnt_next        = 16'd0;
                halted_next     = (max_iter_reg == 16'd0);
            end
            OP_STEP: begin
                if (step_ok) begin
                    cur_next    = lane_par;
                    step_next   = lane_step;
                    prev_next   = lane_grad;
                    cnt_next    = cnt_inc;
                    halted_next = (sumsq <= SUM_W'(eps_sq_reg)) || (cnt_inc >= max_iter_reg);
                end else begin
                    halted_next = 1'b1;
                end
            end
            OP_SCORE: begin
                if (in_fin_reg && (!any_reg || (in_score_reg > best_score_reg))) begin
                    best_score_next = in_score_reg;
                    any_next        = 1'b1;
                    best_next       = cur_reg;
                end
            end
            OP_FINISH: begin
                for (int i = 0; i < NUM_PARAMS; i++) begin
                    cur_next[i] = any_reg ? best_reg[i] : 32'sd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PARAMS; i++) begin
                cur_reg[i]  <= 32'sd0;
                step_reg[i] <= 32'd0;
                prev_reg[i] <= 32'sd0;
                best_reg[i] <= 32'sd0;
            end
            best_score_reg <= S32_MIN;
            any_reg        <= 1'b0;
            cnt_reg        <= 16'd0;
            halted_reg     <= 1'b0;
        end else if (proc) begin
            cur_reg        <= cur_next;
            step_reg       <= step_next;
            prev_reg       <= prev_next;
            best_reg       <= best_next;
            best_score_reg <= best_score_next;
            any_reg        <= any_next;
            cnt_reg        <= cnt_next;
            halted_reg     <= halted_next;
        end
    end

    // ---------------- result register ----------------
    opcode_t            out_kind_reg;
    logic signed [31:0] out_par_reg [NUM_PARAMS];
    logic               out_stop_reg;
    logic [15:0]        out_iter_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            out_kind_reg <= in_op_reg;
            out_par_reg  <= cur_next;
            out_stop_reg <= halted_next;
            out_iter_reg <= cnt_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_kind_reg;

    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < NUM_PARAMS; i++) begin
            m_tdata[32*i +: 32] = out_par_reg[i];
        end
        m_tdata[32*NUM_PARAMS]           = out_stop_reg;
        m_tdata[32*NUM_PARAMS+1 +: 16]   = out_iter_reg;
    end

`ifndef NO_ASSERTIONS
    // only a start beat can release the stop
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg && !(proc && in_op_reg == OP_START) |=> halted_reg)
        else $error("halt cleared without a start beat");

    a_step_count: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && in_op_reg == OP_STEP && step_ok |=> cnt_reg == 16'($past(cnt_reg) + 16'd1))
        else $error("iteration count did not advance on a live step");

    a_best_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !any_reg |-> best_score_reg == S32_MIN)
        else $error("best score set without a finite score");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !out_free |=> in_vld_reg && $stable(in_op_reg))
        else $error("pending input beat lost while result stalled");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for resilient_backprop_step_unit: APB register set-up, stream beats
// in and out, and a local iRprop- predictor checked per beat. Depends on rtl/rbsu_pkg.sv.
module tb_top;
    import rbsu_pkg::*;

    localparam int S_W            = ((32 * 4 + 33 + 7) / 8) * 8;
    localparam int M_W            = ((32 * 4 + 17 + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        opcode_t          kind;
        logic [3:0][31:0] par;
        logic             stopped;
        logic [15:0]      iter;
    } opt_result_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // value_0 .. value_3, score, score_finite, zero pad
    logic [S_W-1:0]   s_tdata  = '0;
    // opcode
    logic [1:0]       s_tuser  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // param_0 .. param_3, stopped, iteration, zero pad
    logic [M_W-1:0]   m_tdata;
    // result_kind
    logic [1:0]       m_tuser;
    logic             psel     = 1'b0;
    logic             penable  = 1'b0;
    logic             pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]      pwdata   = '0;
    logic [31:0]      prdata;
    logic             pready;

    // predictor state and its copy of the registers
    logic signed [31:0] cur_param  [4] = '{default: '0};
    logic signed [31:0] best_param [4] = '{default: '0};
    logic signed [31:0] prev_grad  [4] = '{default: '0};
    logic        [31:0] step_size  [4] = '{default: '0};
    logic signed [31:0] best_score     = S32_MIN;
    logic               score_seen     = 1'b0;
    logic               run_halted     = 1'b0;
    logic        [15:0] steps_taken    = '0;
    logic        [31:0] cfg_delta_init = 32'(RST_DELTA_INIT);
    logic        [31:0] cfg_delta_min  = 32'(RST_DELTA_MIN);
    logic        [31:0] cfg_delta_max  = 32'(RST_DELTA_MAX);
    logic        [31:0] cfg_eta_minus  = 32'(RST_ETA_MINUS);
    logic        [31:0] cfg_eta_plus   = 32'(RST_ETA_PLUS);
    logic        [31:0] cfg_eps_stop   = 32'(RST_EPS_STOP);
    logic        [15:0] cfg_max_iter   = RST_MAX_ITER;

    opt_result_t optimizer_results_due [$];
    opt_result_t opt_want;

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned mismatches   = 0;
    int unsigned input_beats  = 0;
    int unsigned result_beats = 0;
    int unsigned regs_written = 0;
    int unsigned quiet_cycles = 0;

    resilient_backprop_step_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic int sign_of(input logic signed [31:0] v);
        if (v > 0) return 1;
        if (v < 0) return -1;
        return 0;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        end
    endfunction

    // one iRprop- beat applied to the local state; returns the result beat it should produce
    function automatic opt_result_t advance_optimizer(input opcode_t op,
                                                      input logic [3:0][31:0] val,
                                                      input logic signed [31:0] sc,
                                                      input logic fin);
        opt_result_t      r;
        logic signed [31:0] g;
        logic [63:0]      d;
        logic [63:0]      mag;
        logic [63:0]      thresh;
        logic [64:0]      norm_sq;
        longint           moved;
        longint           g_abs;
        int               prod;
        case (op)
            OP_START: begin
                for (int i = 0; i < 4; i++) begin
                    cur_param[i]  = val[i];
                    best_param[i] = val[i];
                    step_size[i]  = cfg_delta_init;
                    prev_grad[i]  = '0;
                end
                best_score  = S32_MIN;
                score_seen  = 1'b0;
                steps_taken = '0;
                run_halted  = (cfg_max_iter == 0);
            end
            OP_STEP: begin
                // a lowered iteration limit stops the run just like the halted flag
                if (run_halted || steps_taken >= cfg_max_iter) begin
                    run_halted = 1'b1;
                end else begin
                    norm_sq = '0;
                    thresh  = 64'(cfg_eps_stop) * 64'(cfg_eps_stop);
                    for (int i = 0; i < 4; i++) begin
                        g    = val[i];
                        prod = sign_of(g) * sign_of(prev_grad[i]);
                        d    = 64'(step_size[i]);
                        if (prod > 0) begin
                            d = (d * 64'(cfg_eta_plus)) >> FRAC_BITS;
                            if (d > 64'(cfg_delta_max)) d = 64'(cfg_delta_max);
                        end else if (prod < 0) begin
                            d = (d * 64'(cfg_eta_minus)) >> FRAC_BITS;
                            if (d < 64'(cfg_delta_min)) d = 64'(cfg_delta_min);
                            g = '0;
                        end
                        step_size[i] = d[31:0];
                        moved = longint'(cur_param[i])
                                - longint'(sign_of(g)) * longint'({32'b0, step_size[i]});
                        if (moved > longint'(S32_MAX)) cur_param[i] = S32_MAX;
                        else if (moved < longint'(S32_MIN)) cur_param[i] = S32_MIN;
                        else cur_param[i] = moved[31:0];
                        prev_grad[i] = g;
                        g_abs = longint'(g);
                        if (g_abs < 0) g_abs = -g_abs;
                        mag = g_abs;
                        norm_sq = norm_sq + {1'b0, mag * mag};
                    end
                    if (norm_sq[64]) norm_sq = {1'b0, {64{1'b1}}};
                    steps_taken = steps_taken + 16'd1;
                    if (norm_sq[63:0] <= thresh || steps_taken >= cfg_max_iter)
                        run_halted = 1'b1;
                end
            end
            OP_SCORE: begin
                if (fin && (!score_seen || sc > best_score)) begin
                    best_score = sc;
                    score_seen = 1'b1;
                    best_param = cur_param;
                end
            end
            OP_FINISH: begin
                for (int i = 0; i < 4; i++)
                    cur_param[i] = score_seen ? best_param[i] : '0;
            end
            default: ;
        endcase
        r.kind = op;
        for (int i = 0; i < 4; i++) r.par[i] = cur_param[i];
        r.stopped = run_halted;
        r.iter    = steps_taken;
        return r;
    endfunction

    // result beats are checked before the input beat of the same edge is predicted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                result_beats++;
                if (optimizer_results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with none expected, actual kind %0d params %h",
                             $time, m_tuser, m_tdata[127:0]);
                end else begin
                    opt_want = optimizer_results_due.pop_front();
                    check_field("result_kind", 32'(opt_want.kind), 32'(m_tuser));
                    for (int i = 0; i < 4; i++)
                        check_field($sformatf("param_%0d", i), opt_want.par[i],
                                    m_tdata[32*i +: 32]);
                    check_field("stopped", 32'(opt_want.stopped), 32'(m_tdata[128]));
                    check_field("iteration", 32'(opt_want.iter), 32'(m_tdata[144:129]));
                end
            end
            if (s_tvalid && s_tready) begin
                input_beats++;
                optimizer_results_due.push_back(advance_optimizer(opcode_t'(s_tuser),
                    s_tdata[127:0], s_tdata[159:128], s_tdata[160]));
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, optimizer_results_due.size());
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic issue(input opcode_t op, input logic [31:0] v0, input logic [31:0] v1,
                         input logic [31:0] v2, input logic [31:0] v3,
                         input logic [31:0] sc, input logic fin);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, fin, sc, v3, v2, v1, v0};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic start_beat(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] d);
        issue(OP_START, a, b, c, d, $urandom, 1'($urandom_range(1)));
    endtask

    task automatic step_beat(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic [31:0] d);
        issue(OP_STEP, a, b, c, d, $urandom, 1'($urandom_range(1)));
    endtask

    task automatic score_beat(input logic [31:0] sc, input logic fin);
        issue(OP_SCORE, $urandom, $urandom, $urandom, $urandom, sc, fin);
    endtask

    task automatic finish_beat;
        issue(OP_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom,
              1'($urandom_range(1)));
    endtask

    task automatic wait_results_drained;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (optimizer_results_due.size() != 0);
    endtask

    // write then read back; the block must be idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] kept;
        case (idx)
            REG_ETA_MINUS: kept = value & 32'h0001_FFFF;
            REG_MAX_ITER:  kept = value & 32'h0000_FFFF;
            default:       kept = value & 32'h7FFF_FFFF;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_DELTA_INIT: cfg_delta_init = kept;
            REG_DELTA_MIN:  cfg_delta_min  = kept;
            REG_DELTA_MAX:  cfg_delta_max  = kept;
            REG_ETA_MINUS:  cfg_eta_minus  = kept;
            REG_ETA_PLUS:   cfg_eta_plus   = kept;
            REG_EPS_STOP:   cfg_eps_stop   = kept;
            REG_MAX_ITER:   cfg_max_iter   = kept[15:0];
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        check_field($sformatf("register %0d readback", idx), kept, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        regs_written++;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: return S32_MAX;
                    1: return S32_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2: return $urandom;
            default: return $urandom_range(0, 1 << 21) - (1 << 20);
        endcase
    endfunction

    function automatic logic [31:0] lane_grad(input bit neg);
        logic [31:0] mag;
        case ($urandom_range(15))
            0: return '0;
            1: return neg ? S32_MIN : S32_MAX;
            2, 3, 4: mag = $urandom_range(1, 255);
            5, 6, 7, 8: mag = $urandom_range(1, 1 << 16);
            9, 10, 11: mag = $urandom_range(1, 1 << 24);
            default: mag = $urandom_range(1, 32'h7FFF_FFFF);
        endcase
        return neg ? -mag : mag;
    endfunction

    // steps, scores and finish with no start: everything acts on the cleared state
    task automatic test_before_start;
        step_beat(32'd1, -32'sd1, 32'd0, 32'd5);
        score_beat(32'd123, 1'b0);
        finish_beat();
    endtask

    task automatic test_step_rules;
        start_beat(S32_MAX, S32_MIN, 32'd0, '1);
        step_beat(S32_MIN, S32_MAX, 32'd1, '1);     // parameters saturate both ways
        step_beat(-32'sd3, 32'd9, 32'd0, 32'd5);    // grow, grow, zero keeps, flip
        score_beat(32'd1000, 1'b0);                 // not finite: ignored
        score_beat(S32_MIN, 1'b1);                  // first finite score taken even at min
        step_beat(-32'sd1, 32'd1, 32'd2, -32'sd2);
        score_beat(S32_MIN, 1'b1);                  // equal is not better
        score_beat(32'd100, 1'b1);
        step_beat(32'd1, -32'sd1, -32'sd2, 32'd2);  // every lane flips: norm zero, halt
        step_beat(32'd4, 32'd4, 32'd4, 32'd4);      // ignored after the stop
        finish_beat();
        step_beat(32'd1, 32'd1, 32'd1, 32'd1);
        wait_results_drained();
    endtask

    task automatic test_register_extremes;
        write_reg(REG_MAX_ITER, 32'd0);
        start_beat(32'd1, 32'd2, 32'd3, 32'd4);     // halts on start
        step_beat(32'd5, 32'd5, 32'd5, 32'd5);
        wait_results_drained();

        write_reg(REG_MAX_ITER, 32'd3);
        write_reg(REG_DELTA_INIT, 32'h7FFF_FFFF);
        write_reg(REG_DELTA_MAX, 32'h7FFF_FFFF);
        write_reg(REG_ETA_PLUS, 32'h7FFF_FFFF);
        write_reg(REG_ETA_MINUS, 32'd0);
        write_reg(REG_DELTA_MIN, 32'd0);
        write_reg(REG_EPS_STOP, 32'h7FFF_FFFF);
        start_beat(32'd0, 32'd0, 32'd0, 32'd0);
        step_beat(S32_MIN, S32_MIN, S32_MIN, S32_MIN); // norm saturates above threshold
        step_beat(S32_MIN, S32_MIN, S32_MIN, S32_MIN); // growth capped, params saturate
        step_beat(32'd1, 32'd1, 32'd1, 32'd1);         // steps collapse to zero
        wait_results_drained();

        write_reg(REG_ETA_MINUS, 32'd65536);
        write_reg(REG_DELTA_MIN, 32'h7FFF_FFFF);
        write_reg(REG_EPS_STOP, 32'd0);
        write_reg(REG_MAX_ITER, 32'd100);
        start_beat(S32_MAX, S32_MIN, 32'd1000, -32'sd1000);
        step_beat(32'd1, -32'sd1, 32'd1, -32'sd1);
        step_beat(-32'sd1, 32'd1, 32'd1, -32'sd1);
        step_beat(32'd3, 32'd0, -32'sd3, 32'd0);
        wait_results_drained();

        // limit dropped below the steps already taken
        write_reg(REG_MAX_ITER, 32'd2);
        step_beat(32'd1, 32'd1, 32'd1, 32'd1);
        wait_results_drained();

        write_reg(REG_MAX_ITER, 32'd65535);
        write_reg(REG_ETA_PLUS, 32'd65536);
        write_reg(REG_DELTA_INIT, 32'd0);
        write_reg(REG_DELTA_MAX, 32'd0);
        start_beat(32'd7, -32'sd7, 32'd0, 32'd1);
        step_beat(32'd2, 32'd2, 32'd2, 32'd2);
        score_beat(32'd5, 1'b1);
        finish_beat();
        wait_results_drained();
    endtask

    // mostly start / steps and scores / finish runs with random content, some noise beats
    task automatic random_session(input int unsigned target);
        int unsigned goal;
        int unsigned len;
        bit          neg [4];
        logic [31:0] g   [4];
        goal = input_beats + target;
        while (input_beats < goal) begin
            if ($urandom_range(9) == 0) begin
                issue(opcode_t'(2'($urandom_range(3))), $urandom, $urandom, $urandom,
                      $urandom, $urandom, 1'($urandom_range(1)));
            end else begin
                start_beat(rand_value(), rand_value(), rand_value(), rand_value());
                for (int k = 0; k < 4; k++) neg[k] = 1'($urandom_range(1));
                len = $urandom_range(2, 14);
                repeat (len) begin
                    if ($urandom_range(3) == 0) begin
                        score_beat(rand_value(), $urandom_range(9) != 0);
                    end else begin
                        for (int k = 0; k < 4; k++) begin
                            if ($urandom_range(3) == 0) neg[k] = !neg[k];
                            g[k] = lane_grad(neg[k]);
                        end
                        step_beat(g[0], g[1], g[2], g[3]);
                    end
                end
                if ($urandom_range(9) < 7) finish_beat();
            end
        end
    endtask

    task automatic test_random_traffic;
        int unsigned pick;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 54; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 54; end
                default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
            endcase
            for (int c = 0; c < 4; c++) begin
                wait_results_drained();
                write_reg(REG_DELTA_INIT, ($urandom_range(7) == 0) ? 32'h7FFF_FFFF
                                          : $urandom_range(0, 1 << 20));
                write_reg(REG_DELTA_MIN, ($urandom_range(7) == 0)
                                         ? $urandom_range(0, 32'h7FFF_FFFF)
                                         : $urandom_range(0, 2000));
                write_reg(REG_DELTA_MAX, ($urandom_range(7) == 0) ? 32'h7FFF_FFFF
                                         : $urandom_range(1 << 12, 1 << 24));
                write_reg(REG_ETA_MINUS, $urandom_range(0, 65536));
                write_reg(REG_ETA_PLUS, ($urandom_range(7) == 0)
                                        ? $urandom_range(65536, 32'h7FFF_FFFF)
                                        : $urandom_range(65536, 3 << 16));
                write_reg(REG_EPS_STOP, ($urandom_range(1) == 0) ? 0
                                        : $urandom_range(0, 1 << 17));
                pick = $urandom_range(9);
                write_reg(REG_MAX_ITER, (pick == 0) ? 0 : (pick == 1) ? 65535
                                        : $urandom_range(1, 40));
                random_session(55);
            end
        end
        wait_results_drained();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_before_start();
        test_step_rules();
        test_register_extremes();
        test_random_traffic();
        repeat (10) @(posedge aclk);
        if (optimizer_results_due.size() != 0) begin
            mismatches++;
            $display("%0t: results outstanding: expected 0, actual %0d",
                     $time, optimizer_results_due.size());
        end
        $display("Run: %0d input beats, %0d result beats, %0d register writes and readbacks.",
                 input_beats, result_beats, regs_written);
        $display({"Start, step, score and finish under four flow-control mixes; ",
                  "halts by norm, count and lowered limit."});
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
